FILE: rtl/hebp_pkg.sv
// Package for the byte Huffman encoder: sizes, memory word types and FSM-free shared constants.
// No dependencies.
`default_nettype none
package hebp_pkg;
  localparam int SYMBOLS = 256;
  localparam int MAX_CODE_BITS = 48;
  localparam int COUNT_BITS = 32;
  localparam int NODE_MAX = 2 * SYMBOLS - 1;
  localparam int SYM_W = 8;
  localparam int NODE_W = $clog2(NODE_MAX + 1);
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int WGT_W = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [MAX_CODE_BITS-1:0] code_t;
endpackage
`default_nettype wire

FILE: rtl/hebp_if.sv
// Valid/ready channel interfaces for the input symbols and the output bytes.
// No dependencies.
`default_nettype none
interface hebp_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] symbol;
  logic last_symbol;
  modport source (output valid, kind, symbol, last_symbol, input ready);
  modport sink (input valid, kind, symbol, last_symbol, output ready);
endinterface

interface hebp_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic last_byte;
  logic status;
  modport source (output valid, out_byte, last_byte, status, input ready);
  modport sink (input valid, out_byte, last_byte, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/huffman_encoder_byte_packer.sv
// Byte Huffman encoder, two passes. Counting item: read, add, write histogram.
// Last counting item: load nodes; per merge, two scans of N nodes (S_SCANW reads a node,
// S_SCAN compares it) and a merge write; each leaf walk reads one parent per tree level.
// Encoding item: table read, one code bit per unstalled S_EBIT step, S_ELAST on the last;
// bytes via output reg. Reset: control, flags and pending bits cleared; histogram cleared
// by an S_CLR pass at the first counting item of each pass (no requests taken during it).
`default_nettype none
module huffman_encoder_byte_packer (
  input wire logic clk,
  input wire logic rst,
  hebp_in_if.sink   in_ch,
  hebp_out_if.source out_ch
);
  import hebp_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_CRD    = 5'd2;
  localparam logic [4:0] S_CWR    = 5'd3;
  localparam logic [4:0] S_INIT   = 5'd4;
  localparam logic [4:0] S_INIT2  = 5'd5;
  localparam logic [4:0] S_SCAN   = 5'd6;
  localparam logic [4:0] S_SCANW  = 5'd7;
  localparam logic [4:0] S_MERGE  = 5'd8;
  localparam logic [4:0] S_LEAF   = 5'd9;
  localparam logic [4:0] S_LEAFW  = 5'd10;
  localparam logic [4:0] S_WALK   = 5'd11;
  localparam logic [4:0] S_WALKW  = 5'd12;
  localparam logic [4:0] S_MUL    = 5'd13;
  localparam logic [4:0] S_HDR    = 5'd14;
  localparam logic [4:0] S_ERD    = 5'd15;
  localparam logic [4:0] S_ERDW   = 5'd16;
  localparam logic [4:0] S_EBIT   = 5'd17;
  localparam logic [4:0] S_ELAST  = 5'd18;
  localparam logic [4:0] S_WALK2  = 5'd19;

  logic [4:0] state;

  // histogram
  logic hist_we;
  sym_t hist_wa, hist_ra;
  logic [COUNT_BITS-1:0] hist_wd, hist_rd;
  hebp_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd), .raddr(hist_ra), .rdata(hist_rd)
  );
  // node weight + live bit
  logic nw_we;
  node_t nw_wa, nw_ra;
  logic [WGT_W:0] nw_wd, nw_rd;
  hebp_ram #(.WIDTH(WGT_W + 1), .DEPTH(512)) u_nw (
    .clk(clk), .we(nw_we), .waddr(nw_wa), .wdata(nw_wd), .raddr(nw_ra), .rdata(nw_rd)
  );
  // node parent + side
  logic np_we;
  node_t np_wa, np_ra;
  logic [NODE_W:0] np_wd, np_rd;
  hebp_ram #(.WIDTH(NODE_W + 1), .DEPTH(512)) u_np (
    .clk(clk), .we(np_we), .waddr(np_wa), .wdata(np_wd), .raddr(np_ra), .rdata(np_rd)
  );
  // code table: length and bits
  logic ct_we;
  sym_t ct_wa, ct_ra;
  logic [LEN_W+MAX_CODE_BITS-1:0] ct_wd, ct_rd;
  hebp_ram #(.WIDTH(LEN_W + MAX_CODE_BITS), .DEPTH(SYMBOLS)) u_ct (
    .clk(clk), .we(ct_we), .waddr(ct_wa), .wdata(ct_wd), .raddr(ct_ra), .rdata(ct_rd)
  );

  logic count_open, overflow_flag;
  logic [COUNT_BITS-1:0] total_count;
  logic [7:0] pending_bits;
  logic [2:0] pending_count;
  logic [2:0] bit_sum;          // total code bits mod 8
  sym_t cur_sym;
  logic cur_last;
  node_t idx, nodes, root, va, vb, best;
  wgt_t best_w, wa_w;
  logic have_best, pick_b, root_ok;
  logic scan_take;
  logic [8:0] dfull;
  code_t code;
  logic [WGT_W:0] sum_w;
  logic [COUNT_BITS-1:0] leaf_cnt;
  len_t len_reg;
  code_t ecode;
  len_t ebits;

  logic ov, ovalid, load_out;
  logic [7:0] obyte;
  logic olast;

  assign out_ch.valid = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.last_byte = olast;
  assign out_ch.status = overflow_flag;
  assign ov = ovalid && !out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && !ov;
  assign load_out = !ov && ((state == S_HDR) || (state == S_ELAST) ||
                    ((state == S_EBIT) && (ebits != '0) && (pending_count == 3'd7)));

  // node under scan (idx - 1) beats the best so far; a is skipped while picking b
  assign scan_take = nw_rd[WGT_W] && !(pick_b && (idx - 1'b1) == va) &&
                     (!have_best || nw_rd[WGT_W-1:0] < best_w);

  wire in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    hist_we = 1'b0; hist_wa = idx[SYM_W-1:0]; hist_wd = '0; hist_ra = cur_sym;
    nw_we = 1'b0; nw_wa = idx; nw_wd = '0; nw_ra = idx;
    np_we = 1'b0; np_wa = va; np_wd = '0; np_ra = idx;
    ct_we = 1'b0; ct_wa = idx[SYM_W-1:0]; ct_wd = '0; ct_ra = cur_sym;
    unique case (state)
      S_CLR: begin
        hist_we = 1'b1;
      end
      S_CWR: begin
        hist_we = 1'b1; hist_wa = cur_sym; hist_wd = hist_rd + 1'b1;
      end
      S_INIT: hist_ra = idx[SYM_W-1:0];
      S_INIT2: begin
        hist_ra = idx[SYM_W-1:0];
        nw_we = 1'b1; nw_wa = idx - 1'b1;
        nw_wd = {hist_rd != '0, 1'b0, hist_rd};
        ct_we = 1'b1; ct_wa = sym_t'(idx - 1'b1); ct_wd = '0;
      end
      S_MERGE: begin
        nw_we = 1'b1;
        unique case (idx[1:0])
          2'd0: begin nw_wa = va; nw_wd = {1'b0, wa_w}; end
          2'd1: begin nw_wa = vb; nw_wd = {1'b0, best_w}; end
          default: begin nw_wa = nodes; nw_wd = {1'b1, sum_w[WGT_W-1:0]}; end
        endcase
        np_we = (idx[1:0] != 2'd2);
        np_wa = (idx[1:0] == 2'd0) ? va : vb;
        np_wd = {idx[0], nodes};
      end
      S_LEAF: hist_ra = idx[SYM_W-1:0];
      S_WALK, S_WALKW, S_WALK2: np_ra = idx;
      S_MUL: begin
        hist_ra = cur_sym + 1'b1;
        ct_we = 1'b1; ct_wa = cur_sym; ct_wd = {len_reg, code};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_out) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count_open <= 1'b0; overflow_flag <= 1'b0; total_count <= '0;
      pending_bits <= '0; pending_count <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_acc) begin
          cur_sym <= in_ch.symbol; cur_last <= in_ch.last_symbol;
          if (!in_ch.kind) begin
            if (!count_open) begin
              count_open <= 1'b1; total_count <= '0; overflow_flag <= 1'b0;
              idx <= '0; state <= S_CLR;
            end else state <= S_CRD;
          end else state <= S_ERD;
        end
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == node_t'(SYMBOLS - 1)) state <= S_CRD;
        end
        S_CRD: begin
          if (total_count == COUNT_LIMIT) begin
            overflow_flag <= 1'b1;
            state <= cur_last ? S_INIT : S_IDLE;
            idx <= '0;
          end else begin
            total_count <= total_count + 1'b1;
            state <= S_CWR;
          end
        end
        S_CWR: begin
          idx <= '0;
          state <= cur_last ? S_INIT : S_IDLE;
        end
        S_INIT: begin idx <= node_t'(1); state <= S_INIT2; end
        S_INIT2: begin
          if (idx == node_t'(SYMBOLS)) begin
            nodes <= node_t'(SYMBOLS); idx <= '0; have_best <= 1'b0; pick_b <= 1'b0;
            root_ok <= 1'b0; state <= S_SCANW;
          end else idx <= idx + 1'b1;
        end
        // scan: address idx issued in S_SCANW, its data arrives in the next cycle (S_SCAN)
        S_SCANW: begin idx <= idx + 1'b1; state <= S_SCAN; end
        S_SCAN: begin
          if (idx != nodes) begin
            if (scan_take) begin
              have_best <= 1'b1; best <= idx - 1'b1; best_w <= nw_rd[WGT_W-1:0];
            end
            state <= S_SCANW;
          end else if (!pick_b) begin
            if (!have_best && !scan_take) begin
              root_ok <= 1'b0; idx <= '0; state <= S_LEAF;
            end else begin
              va <= scan_take ? idx - 1'b1 : best;
              wa_w <= scan_take ? nw_rd[WGT_W-1:0] : best_w;
              pick_b <= 1'b1; have_best <= 1'b0; idx <= '0; state <= S_SCANW;
            end
          end else begin
            if ((!have_best && !scan_take) || nodes >= node_t'(NODE_MAX)) begin
              root <= va; root_ok <= 1'b1; idx <= '0; state <= S_LEAF;
            end else begin
              vb <= scan_take ? idx - 1'b1 : best;
              if (scan_take) best_w <= nw_rd[WGT_W-1:0];
              idx <= '0; state <= S_MERGE;
            end
          end
        end
        S_MERGE: begin
          if (idx == '0) sum_w <= {1'b0, wa_w} + {1'b0, best_w};
          if (idx[1:0] == 2'd2) begin
            nodes <= nodes + 1'b1; idx <= '0; pick_b <= 1'b0; have_best <= 1'b0;
            state <= S_SCANW;
          end else idx <= idx + 1'b1;
        end
        // per-leaf code walk; cur_sym doubles as the leaf counter
        S_LEAF: begin cur_sym <= idx[SYM_W-1:0]; bit_sum <= '0; state <= S_LEAFW; end
        S_LEAFW: begin
          leaf_cnt <= hist_rd;
          if (hist_rd == '0 || !root_ok) begin
            len_reg <= '0; code <= '0; state <= S_MUL;
          end else if (node_t'(cur_sym) == root) begin
            len_reg <= len_t'(1); code <= '0; state <= S_MUL;
          end else begin
            idx <= node_t'(cur_sym); dfull <= '0; code <= '0; state <= S_WALKW;
          end
        end
        S_WALKW: state <= S_WALK;
        S_WALK: begin
          // code built LSB first (leaf side); past MAX_CODE_BITS levels shift right so the
          // levels nearest the root are kept
          if (dfull < 9'(MAX_CODE_BITS)) code[dfull[LEN_W-1:0]] <= np_rd[NODE_W];
          else code <= {np_rd[NODE_W], code[MAX_CODE_BITS-1:1]};
          dfull <= dfull + 1'b1;
          if (np_rd[NODE_W-1:0] == root) state <= S_WALK2;
          else begin idx <= np_rd[NODE_W-1:0]; state <= S_WALKW; end
        end
        S_WALK2: begin
          if (dfull > 9'(MAX_CODE_BITS)) begin
            overflow_flag <= 1'b1; len_reg <= len_t'(MAX_CODE_BITS);
          end else len_reg <= len_t'(dfull);
          state <= S_MUL;
        end
        S_MUL: begin
          bit_sum <= bit_sum + 3'(leaf_cnt[2:0] * len_reg[2:0]);
          if (cur_sym == sym_t'(SYMBOLS - 1)) state <= S_HDR;
          else begin idx <= node_t'(cur_sym) + 1'b1; cur_sym <= cur_sym + 1'b1;
            state <= S_LEAFW; end
        end
        S_HDR: if (!ov) begin
          obyte <= 8'd8 - {5'd0, bit_sum}; olast <= 1'b1;
          count_open <= 1'b0; pending_bits <= '0; pending_count <= '0;
          state <= S_IDLE;
        end
        S_ERD: state <= S_ERDW;
        S_ERDW: begin
          ebits <= ct_rd[LEN_W+MAX_CODE_BITS-1:MAX_CODE_BITS];
          ecode <= ct_rd[MAX_CODE_BITS-1:0];
          state <= S_EBIT;
        end
        S_EBIT: if (!ov) begin
          if (ebits == '0) state <= cur_last ? S_ELAST : S_IDLE;
          else begin
            pending_bits <= {pending_bits[6:0], ecode[ebits - 1'b1]};
            pending_count <= pending_count + 1'b1;
            ebits <= ebits - 1'b1;
            if (pending_count == 3'd7) begin
              obyte <= {pending_bits[6:0], ecode[ebits - 1'b1]};
              // fewer than 8 bits left after this one: no further byte from this request
              olast <= (ebits <= len_t'(8)) && !cur_last;
            end
          end
        end
        S_ELAST: if (!ov) begin
          olast <= 1'b1;
          obyte <= pending_bits << (4'd8 - {1'b0, pending_count});
          pending_bits <= '0; pending_count <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hebp_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module hebp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
